FILE: rtl/hzi_pkg.sv
// Shared types, codes and decode helpers for the pipeline hazard interlock.
`default_nettype none
package hzi_pkg;

    // Width of the internal sequence tag and of the tag fields on the result
    localparam int TAG_BITS     = 8;
    localparam int OUT_TAG_BITS = 8;
    localparam int EXT_TAG_BITS = (TAG_BITS > OUT_TAG_BITS) ? TAG_BITS : OUT_TAG_BITS;
    localparam int REG_BITS     = 5;
    localparam int WORD_BITS    = 32;
    localparam int OPCODE_BITS  = 7;

    // Opcodes that read source registers
    localparam logic [OPCODE_BITS-1:0] OP_IMM = 7'h13;
    localparam logic [OPCODE_BITS-1:0] OP_REG = 7'h33;

    // ID status codes
    localparam logic [1:0] ID_EMPTY = 2'd0;
    localparam logic [1:0] ID_FIRST = 2'd1;
    localparam logic [1:0] ID_STALL = 2'd2;
    localparam logic [1:0] ID_ISSUE = 2'd3;

    typedef logic [TAG_BITS-1:0]     t_tag;
    typedef logic [REG_BITS-1:0]     t_reg;
    typedef logic [OUT_TAG_BITS-1:0] t_out_tag;

    typedef struct packed {
        logic                 valid;
        t_tag                 tag;
        logic [WORD_BITS-1:0] word;
    } t_fetch;

    typedef struct packed {
        logic valid;
        logic first;
        t_tag tag;
        t_reg dst;
        t_reg src_a;
        t_reg src_b;
    } t_decode;

    typedef struct packed {
        logic valid;
        t_tag tag;
        t_reg dst;
    } t_later;

    typedef struct packed {
        t_fetch  fetch;
        t_decode decode;
        t_later  ex;
        t_later  mem;
        t_later  wb;
    } t_stages;

    // Interlock decision for the current cycle
    typedef struct packed {
        logic [1:0] status;
        logic       hold;
    } t_ctrl;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic       fetch_taken;
        logic       stall_res;
        t_out_tag   wb_tag;
        logic       wb_valid;
        t_out_tag   mem_tag;
        logic       mem_valid;
        t_out_tag   ex_tag;
        logic       ex_valid;
        t_out_tag   id_tag;
        logic [1:0] id_status;
        t_out_tag   if_tag;
        logic       if_valid;
    } t_result;

    // Low bits of a tag as shown on the result, zero-extended if narrower
    function automatic t_out_tag out_tag(input t_tag tag);
        logic [EXT_TAG_BITS-1:0] ext;
        ext = EXT_TAG_BITS'(tag);
        return ext[OUT_TAG_BITS-1:0];
    endfunction

    // Decode an instruction word into its ID stage contents
    function automatic t_decode decode_word(input t_tag tag, input logic [WORD_BITS-1:0] w);
        t_decode d;
        d.valid = 1'b1;
        d.first = 1'b1;
        d.tag   = tag;
        d.dst   = w[11:7];
        d.src_a = '0;
        d.src_b = '0;
        if (w[OPCODE_BITS-1:0] == OP_IMM) begin
            d.src_a = w[19:15];
        end else if (w[OPCODE_BITS-1:0] == OP_REG) begin
            d.src_a = w[19:15];
            d.src_b = w[24:20];
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hzi_hazard.sv
// Hazard detection: ID status and hold decision from the current stage contents.
`default_nettype none
module hzi_hazard (
    input  hzi_pkg::t_stages i_stages,
    output hzi_pkg::t_ctrl   o_ctrl
);

    // A later stage blocks ID when it will write a register that ID reads
    function automatic logic blocks(input hzi_pkg::t_later s, input hzi_pkg::t_decode d);
        logic hit_a;
        logic hit_b;
        hit_a = (d.src_a != '0) && (d.src_a == s.dst);
        hit_b = (d.src_b != '0) && (d.src_b == s.dst);
        return s.valid && (s.dst != '0) && (hit_a || hit_b);
    endfunction

    logic any_block;

    assign any_block = blocks(i_stages.ex,  i_stages.decode)
                     | blocks(i_stages.mem, i_stages.decode)
                     | blocks(i_stages.wb,  i_stages.decode);

    // Classify ID: empty, first-cycle hold, hazard stall or issue
    always_comb begin
        if (!i_stages.decode.valid) begin
            o_ctrl.status = hzi_pkg::ID_EMPTY;
        end else if (i_stages.decode.first) begin
            o_ctrl.status = hzi_pkg::ID_FIRST;
        end else if (any_block) begin
            o_ctrl.status = hzi_pkg::ID_STALL;
        end else begin
            o_ctrl.status = hzi_pkg::ID_ISSUE;
        end
        o_ctrl.hold = (o_ctrl.status == hzi_pkg::ID_FIRST)
                   || (o_ctrl.status == hzi_pkg::ID_STALL);
    end

endmodule
`default_nettype wire

FILE: rtl/hzi_pipe.sv
// Stage registers of the five-stage pipeline and the fetch tag counter.
`default_nettype none
module hzi_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_offer,
    input  logic [hzi_pkg::WORD_BITS-1:0]     i_word,
    input  hzi_pkg::t_ctrl                    i_ctrl,
    output hzi_pkg::t_stages                  o_stages,
    output logic                              o_taken
);

    hzi_pkg::t_stages r_stages;
    hzi_pkg::t_stages n_stages;
    hzi_pkg::t_tag    r_next_tag;
    hzi_pkg::t_tag    n_next_tag;

    assign o_stages = r_stages;
    assign o_taken  = i_offer && !i_ctrl.hold;

    // Next stage contents for one tick
    always_comb begin
        n_stages   = r_stages;
        n_next_tag = r_next_tag;

        // Advance the back end unconditionally
        n_stages.wb  = r_stages.mem;
        n_stages.mem = r_stages.ex;
        if (i_ctrl.status == hzi_pkg::ID_ISSUE) begin
            n_stages.ex.valid = 1'b1;
            n_stages.ex.tag   = r_stages.decode.tag;
            n_stages.ex.dst   = r_stages.decode.dst;
        end else begin
            n_stages.ex = '0;
        end

        // Hold IF and ID, or move IF into ID and fetch
        if (i_ctrl.hold) begin
            n_stages.decode.first = 1'b0;
        end else begin
            if (r_stages.fetch.valid) begin
                n_stages.decode = hzi_pkg::decode_word(r_stages.fetch.tag,
                                                       r_stages.fetch.word);
            end else begin
                n_stages.decode = '0;
            end
            if (o_taken) begin
                n_stages.fetch.valid = 1'b1;
                n_stages.fetch.tag   = r_next_tag;
                n_stages.fetch.word  = i_word;
                n_next_tag           = hzi_pkg::TAG_BITS'(r_next_tag + 1'b1);
            end else begin
                n_stages.fetch = '0;
            end
        end
    end

    // Update state once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages   <= '0;
            r_next_tag <= '0;
        end else if (i_advance) begin
            r_stages   <= n_stages;
            r_next_tag <= n_next_tag;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pipeline_hazard_interlock.sv
// Top level of the pipeline hazard interlock: stream handshake and result register.
//
// Each input item is one clock tick of a five-stage in-order pipeline without
// forwarding; it may offer an instruction word (tuser high). The block reports
// the stage contents and interlock decision of that tick as one result item and
// then advances its stage registers. An item is accepted every clock cycle while
// the result register is empty or being drained, so the sustained rate is one
// item per cycle; the result appears in the cycle after acceptance, from the
// single result register behind the hazard logic. When the output is stalled
// the input is held off until the waiting result is taken.
`default_nettype none
module pipeline_hazard_interlock (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] fetch_word
    input  logic        s_axis_tuser,   // [0] fetch_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [0] if_valid, [8:1] if_tag, [10:9] id_status,
                                        // [18:11] id_tag, [19] ex_valid, [27:20] ex_tag,
                                        // [28] mem_valid, [36:29] mem_tag, [37] wb_valid,
                                        // [45:38] wb_tag, [46] stall_res, [47] fetch_taken
);

    hzi_pkg::t_stages stages;
    hzi_pkg::t_ctrl   ctrl;
    hzi_pkg::t_result result;
    logic             accept;
    logic             taken;

    logic             r_out_valid;
    hzi_pkg::t_result r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hzi_hazard u_hazard (
        .i_stages (stages),
        .o_ctrl   (ctrl)
    );

    hzi_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_offer   (s_axis_tuser),
        .i_word    (s_axis_tdata),
        .i_ctrl    (ctrl),
        .o_stages  (stages),
        .o_taken   (taken)
    );

    // Assemble the result item; an empty stage shows tag zero
    always_comb begin
        result.if_valid    = stages.fetch.valid;
        result.if_tag      = stages.fetch.valid ? hzi_pkg::out_tag(stages.fetch.tag) : '0;
        result.id_status   = ctrl.status;
        result.id_tag      = stages.decode.valid ? hzi_pkg::out_tag(stages.decode.tag) : '0;
        result.ex_valid    = stages.ex.valid;
        result.ex_tag      = stages.ex.valid ? hzi_pkg::out_tag(stages.ex.tag) : '0;
        result.mem_valid   = stages.mem.valid;
        result.mem_tag     = stages.mem.valid ? hzi_pkg::out_tag(stages.mem.tag) : '0;
        result.wb_valid    = stages.wb.valid;
        result.wb_tag      = stages.wb.valid ? hzi_pkg::out_tag(stages.wb.tag) : '0;
        result.stall_res   = ctrl.hold;
        result.fetch_taken = taken;
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire

FILE: rtl/hzi_checker.sv
// Port-level checker for the pipeline hazard interlock, with its bind.
`default_nettype none
module hzi_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);

    hzi_pkg::t_result cur;
    hzi_pkg::t_result r_prev;
    logic             r_have;
    logic             out_acc;

    assign cur     = m_axis_tdata;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Remember the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_prev <= '0;
        end else if (out_acc) begin
            r_have <= 1'b1;
            r_prev <= cur;
        end
    end

    // A first-cycle hold is followed by a stall or an issue of the same item
    a_first_then_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have && r_prev.id_status == hzi_pkg::ID_FIRST |->
        (cur.id_status == hzi_pkg::ID_STALL || cur.id_status == hzi_pkg::ID_ISSUE)
        && cur.id_tag == r_prev.id_tag)
        else $error("first-cycle hold not followed by stall or issue of same item");

    // An issued item shows up in EX on the next tick
    a_issue_to_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have && r_prev.id_status == hzi_pkg::ID_ISSUE |->
        cur.ex_valid && cur.ex_tag == r_prev.id_tag)
        else $error("issued item missing from EX");

    // EX moves into MEM unconditionally
    a_ex_to_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have |->
        cur.mem_valid == r_prev.ex_valid && cur.mem_tag == r_prev.ex_tag)
        else $error("EX contents did not move into MEM");

    // A held tick keeps IF unchanged
    a_hold_keeps_if: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have && r_prev.stall_res |->
        cur.if_valid == r_prev.if_valid && cur.if_tag == r_prev.if_tag)
        else $error("IF changed during a hold");

    // Output valid stays up until taken
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result withdrawn or changed while stalled");

endmodule

bind pipeline_hazard_interlock hzi_checker u_hzi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for pipeline_hazard_interlock: stage-by-stage prediction of every result item.
`timescale 1ns / 1ps
module tb;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;
    localparam logic [6:0] OP_LOAD = 7'h03;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] fetch_word
    logic        s_axis_tuser;   // [0] fetch_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [0] if_valid, [8:1] if_tag, [10:9] id_status,
                                 // [18:11] id_tag, [19] ex_valid, [27:20] ex_tag,
                                 // [28] mem_valid, [36:29] mem_tag, [37] wb_valid,
                                 // [45:38] wb_tag, [46] stall_res, [47] fetch_taken

    // Predicted pipeline contents
    hzi_pkg::t_fetch  pred_fetch = '0;
    hzi_pkg::t_decode pred_dec   = '0;
    hzi_pkg::t_later  pred_ex    = '0;
    hzi_pkg::t_later  pred_mem   = '0;
    hzi_pkg::t_later  pred_wb    = '0;
    hzi_pkg::t_tag    pred_next_tag = '0;

    hzi_pkg::t_result stage_reports_q[$];
    int      fail_count   = 0;
    int      cycle_count  = 0;
    int      rx_hold_left = 0;
    logic    idle_on      = 1'b1;

    pipeline_hazard_interlock dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Split an instruction word into its ID contents
    function automatic hzi_pkg::t_decode split_word(input hzi_pkg::t_tag tag,
                                                    input logic [31:0] w);
        hzi_pkg::t_decode d;
        d = '0;
        d.valid = 1'b1;
        d.first = 1'b1;
        d.tag   = tag;
        d.dst   = w[11:7];
        if (w[6:0] == hzi_pkg::OP_IMM) begin
            d.src_a = w[19:15];
        end else if (w[6:0] == hzi_pkg::OP_REG) begin
            d.src_a = w[19:15];
            d.src_b = w[24:20];
        end
        return d;
    endfunction

    // A later stage blocks ID when it will write a nonzero register that ID reads
    function automatic logic writes_source(input hzi_pkg::t_later s,
                                           input hzi_pkg::t_decode d);
        if (!s.valid || s.dst == '0) begin
            return 1'b0;
        end
        return (d.src_a != '0 && d.src_a == s.dst) || (d.src_b != '0 && d.src_b == s.dst);
    endfunction

    // Report the current tick and advance the predicted pipeline
    task automatic predict_tick(input logic offer, input logic [31:0] word);
        hzi_pkg::t_result r;
        logic [1:0]       status;
        logic             hold;
        logic             taken;
        status = hzi_pkg::ID_EMPTY;
        if (pred_dec.valid) begin
            if (pred_dec.first) begin
                status = hzi_pkg::ID_FIRST;
            end else if (writes_source(pred_ex, pred_dec) || writes_source(pred_mem, pred_dec)
                         || writes_source(pred_wb, pred_dec)) begin
                status = hzi_pkg::ID_STALL;
            end else begin
                status = hzi_pkg::ID_ISSUE;
            end
        end
        hold  = (status == hzi_pkg::ID_FIRST) || (status == hzi_pkg::ID_STALL);
        taken = offer && !hold;

        r.if_valid    = pred_fetch.valid;
        r.if_tag      = pred_fetch.valid ? pred_fetch.tag : '0;
        r.id_status   = status;
        r.id_tag      = pred_dec.valid ? pred_dec.tag : '0;
        r.ex_valid    = pred_ex.valid;
        r.ex_tag      = pred_ex.valid ? pred_ex.tag : '0;
        r.mem_valid   = pred_mem.valid;
        r.mem_tag     = pred_mem.valid ? pred_mem.tag : '0;
        r.wb_valid    = pred_wb.valid;
        r.wb_tag      = pred_wb.valid ? pred_wb.tag : '0;
        r.stall_res   = hold;
        r.fetch_taken = taken;
        stage_reports_q = {stage_reports_q, r};

        pred_wb  = pred_mem;
        pred_mem = pred_ex;
        pred_ex  = '0;
        if (status == hzi_pkg::ID_ISSUE) begin
            pred_ex.valid = 1'b1;
            pred_ex.tag   = pred_dec.tag;
            pred_ex.dst   = pred_dec.dst;
        end
        if (hold) begin
            pred_dec.first = 1'b0;
        end else begin
            pred_dec = pred_fetch.valid ? split_word(pred_fetch.tag, pred_fetch.word) : '0;
            pred_fetch = '0;
            if (taken) begin
                pred_fetch.valid = 1'b1;
                pred_fetch.tag   = pred_next_tag;
                pred_fetch.word  = word;
                pred_next_tag    = pred_next_tag + 1'b1;
            end
        end
    endtask

    // Instruction encoders with random filler bits
    function automatic logic [31:0] imm_word(input hzi_pkg::t_reg rd, input hzi_pkg::t_reg rs1);
        return {12'($urandom), rs1, 3'($urandom), rd, hzi_pkg::OP_IMM};
    endfunction

    function automatic logic [31:0] reg_word(input hzi_pkg::t_reg rd, input hzi_pkg::t_reg rs1,
                                             input hzi_pkg::t_reg rs2);
        return {7'($urandom), rs2, rs1, 3'($urandom), rd, hzi_pkg::OP_REG};
    endfunction

    // Mostly a few hot registers so that hazards are frequent
    function automatic hzi_pkg::t_reg pick_reg();
        return ($urandom_range(0, 4) == 0) ? hzi_pkg::t_reg'($urandom_range(0, 31))
                                           : hzi_pkg::t_reg'($urandom_range(0, 3));
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = imm_word(pick_reg(), pick_reg());
            4, 5, 6:    w = reg_word(pick_reg(), pick_reg(), pick_reg());
            7:          w = {$urandom} & ~32'h0000_0F80 | {20'h0, pick_reg(), 7'h0};
            default:    w = $urandom;
        endcase
        return w;
    endfunction

    // Offer one item, with an optional random gap before it; return once accepted
    task automatic send_item(input logic offer, input logic [31:0] word);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= offer;
        s_axis_tdata  <= word;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_tick(offer, word);
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_item($urandom_range(0, 6) != 0, pick_word());
        end
    endtask

    // Hold the input off until every predicted result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (stage_reports_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Words that read nothing, all-zero and all-one words, ticks with no offer
    task automatic test_plain_flow();
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b1, 32'hFFFF_FFFF);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b1, 32'h0000_0013);
    endtask

    // Immediate op reads rs1; a destination of x0 never blocks
    task automatic test_imm_hazard();
        send_item(1'b1, imm_word(5'd1, 5'd0));
        send_item(1'b1, imm_word(5'd2, 5'd1));
        send_item(1'b1, imm_word(5'd0, 5'd2));
        send_item(1'b1, imm_word(5'd3, 5'd0));
    endtask

    // Register op reads rs1 and rs2; a load is a producer too
    task automatic test_reg_hazard();
        send_item(1'b1, reg_word(5'd5, 5'd0, 5'd0));
        send_item(1'b1, reg_word(5'd6, 5'd0, 5'd5));
        send_item(1'b1, reg_word(5'd7, 5'd6, 5'd7));
        send_item(1'b1, {20'h12345, 5'd9, OP_LOAD});
        send_item(1'b1, reg_word(5'd10, 5'd9, 5'd9));
    endtask

    // Producer followed by empty ticks, then a consumer further away
    task automatic test_hazard_distance();
        send_item(1'b1, imm_word(5'd12, 5'd0));
        send_item(1'b0, 32'h0);
        send_item(1'b0, 32'h0);
        send_item(1'b1, imm_word(5'd13, 5'd12));
        send_item(1'b1, reg_word(5'd31, 5'd13, 5'd12));
    endtask

    task automatic test_random_traffic();
        send_random(1050);
    endtask

    // Long receiver hold while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        rx_hold_left = 60;
        send_random(40);
        idle_on = 1'b1;
    endtask

    // Sender pauses until the pipeline reports are all back
    task automatic test_sender_pause();
        send_random(30);
        wait_drained();
        send_random(30);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_random(100);
    endtask

    // Receiver ready: long hold on request, otherwise random stall bursts
    initial begin
        int burst = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        hzi_pkg::t_result got;
        hzi_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = hzi_pkg::t_result'(m_axis_tdata);
            if (stage_reports_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = stage_reports_q.pop_front();
                check_field("if_valid", 32'(want.if_valid), 32'(got.if_valid));
                check_field("if_tag", 32'(want.if_tag), 32'(got.if_tag));
                check_field("id_status", 32'(want.id_status), 32'(got.id_status));
                check_field("id_tag", 32'(want.id_tag), 32'(got.id_tag));
                check_field("ex_valid", 32'(want.ex_valid), 32'(got.ex_valid));
                check_field("ex_tag", 32'(want.ex_tag), 32'(got.ex_tag));
                check_field("mem_valid", 32'(want.mem_valid), 32'(got.mem_valid));
                check_field("mem_tag", 32'(want.mem_tag), 32'(got.mem_tag));
                check_field("wb_valid", 32'(want.wb_valid), 32'(got.wb_valid));
                check_field("wb_tag", 32'(want.wb_tag), 32'(got.wb_tag));
                check_field("stall_res", 32'(want.stall_res), 32'(got.stall_res));
                check_field("fetch_taken", 32'(want.fetch_taken), 32'(got.fetch_taken));
            end
        end
    end

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_flow();
        test_imm_hazard();
        test_reg_hazard();
        test_hazard_distance();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && stage_reports_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
